### hdl/lcis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcis_pkg
// Shared types and constants of the common increasing subsequence engine.
// ----------------------------------------------------------------------------
package lcis_pkg;

  // default sizes
  localparam int FIRST_DEPTH_DEF  = 32;
  localparam int SECOND_DEPTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF  = 32;

  // port field widths
  localparam int CMD_W  = 2;
  localparam int DATA_W = 32;
  localparam int EXT_W  = 64;

  // command codes on the input tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  // result kinds on the output tuser
  localparam logic KIND_LEN  = 1'b0;
  localparam logic KIND_ELEM = 1'b1;

endpackage

### hdl/longest_common_increasing_subseq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_common_increasing_subseq
// Loads two sequences, sweeps the table through a row of column cells and
// traces back one longest common strictly increasing subsequence.
// ----------------------------------------------------------------------------
// channel  dir  tdata              tuser        tlast
// in_      in   value[31:0]        command[1:0] -
// out_     out  value_res[31:0]    kind         last
//
// loads are accepted only while idle; a start blocks input until its last word is loaded into the output register
// sweep: one row word enters the cell row a cycle,
// then the column bests of the M loaded second elements are scanned
// trace: setup in S_TINIT and S_TINIT2, S_TCOL and S_TSEC per column, S_TRD and S_TCHK
// per table read; emit: the length word in S_ELEN, then S_ERD and S_EOUT per element
// reset clears counts and control only; the table is rewritten by each sweep
// an output stall holds the word in the output register and stops emission
module longest_common_increasing_subseq import lcis_pkg::*; #(
  parameter int FIRST_DEPTH  = FIRST_DEPTH_DEF,
  parameter int SECOND_DEPTH = SECOND_DEPTH_DEF,
  parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // value
  input  logic [CMD_W-1:0]  in_tuser,   // command
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // value_res
  output logic              out_tuser,  // kind
  output logic              out_tlast
);

  localparam int FD  = FIRST_DEPTH;
  localparam int SD  = SECOND_DEPTH;
  localparam int VW  = VALUE_WIDTH;
  localparam int FIW = (FD > 1) ? $clog2(FD) : 1;
  localparam int SIW = (SD > 1) ? $clog2(SD) : 1;
  localparam int FCW = $clog2(FD + 1);
  localparam int SCW = $clog2(SD + 1);
  localparam int LW  = $clog2(SD + 1);
  localparam int KW  = $clog2(FD + SD + 4);

  typedef enum logic [3:0] {
    S_IDLE, S_RUN, S_RED, S_TINIT, S_TINIT2, S_TCOL, S_TSEC,
    S_TRD, S_TCHK, S_ELEN, S_ERD, S_EOUT
  } state_t;

  state_t st_r;

  logic signed [VW-1:0] fmem [FD];
  logic signed [VW-1:0] smem [SD];
  logic signed [VW-1:0] amem [SD];
  logic [FCW-1:0]       fcnt_r;
  logic [SCW-1:0]       scnt_r;
  logic [KW-1:0]        k_r;
  logic signed [VW-1:0] f_rd_r;
  logic                 tok0_v_r;
  logic [FIW-1:0]       tok0_row_r;
  logic [SCW-1:0]       j_r;
  logic [LW-1:0]        len_r;
  logic [FIW-1:0]       bi_r;
  logic [SIW-1:0]       bj_r;
  logic signed [VW-1:0] s_rd_r;
  logic signed [VW-1:0] a_rd_r;
  logic signed [VW-1:0] prev_r;
  logic [LW-1:0]        found_r;
  logic [LW-1:0]        need_r;
  logic [FIW-1:0]       rlim_r;
  logic [FIW-1:0]       ti_r;
  logic [SCW-1:0]       jj_r;
  logic [LW-1:0]        ei_r;
  logic                 out_v_r;
  logic [DATA_W-1:0]    out_d_r;
  logic                 out_k_r;
  logic                 out_l_r;

  logic                 acc;
  logic                 out_free;
  logic                 out_load;
  logic signed [EXT_W-1:0] in_ext;
  logic signed [VW-1:0] in_val;
  logic signed [EXT_W-1:0] a_ext;
  logic [SIW-1:0]       s_raddr;
  logic [SIW-1:0]       col_c;
  logic [LW-1:0]        sel_best;
  logic [FIW-1:0]       sel_row;
  logic [LW-1:0]        sel_rd;

  // chain wiring
  logic                 ch_v   [SD+1];
  logic signed [VW-1:0] ch_a   [SD+1];
  logic [LW-1:0]        ch_rm  [SD+1];
  logic [FIW-1:0]       ch_row [SD+1];
  logic [LW-1:0]        c_best [SD];
  logic [FIW-1:0]       c_brow [SD];
  logic [LW-1:0]        c_rd   [SD];
  logic [SD-1:0]        b_we;

  // input handshake and value sign extension
  always_comb begin
    acc      = in_tvalid && in_tready;
    out_free = !out_v_r || out_tready;
    out_load = out_free && ((st_r == S_ELEN) || (st_r == S_EOUT));
    in_ext   = EXT_W'($signed(in_tdata));
    in_val   = in_ext[VW-1:0];
    a_ext    = EXT_W'(a_rd_r);
    col_c    = SIW'(jj_r - SCW'(1));
    sel_best = c_best[j_r[SIW-1:0]];
    sel_row  = c_brow[j_r[SIW-1:0]];
    sel_rd   = c_rd[col_c];
    unique case (st_r)
      S_TINIT: s_raddr = bj_r;
      default: s_raddr = col_c;
    endcase
  end
  assign in_tready = (st_r == S_IDLE);

  // second-sequence load strobes, one per cell
  always_comb begin
    for (int j = 0; j < SD; j++) begin
      b_we[j] = acc && (cmd_t'(in_tuser) == CMD_LOAD_B) && (scnt_r < SCW'(SD)) &&
                (scnt_r[SIW-1:0] == SIW'(j));
    end
  end

  // head of the cell row
  assign ch_v[0]   = tok0_v_r;
  assign ch_a[0]   = f_rd_r;
  assign ch_rm[0]  = '0;
  assign ch_row[0] = tok0_row_r;

  for (genvar g = 0; g < SD; g++) begin : g_cell
    lcis_cell #(.VW(VW), .FD(FD), .SD(SD), .J(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .clear    (acc && (cmd_t'(in_tuser) == CMD_START)),
      .b_we     (b_we[g]),
      .b_val    (in_val),
      .m_cnt    (scnt_r),
      .in_v     (ch_v[g]),
      .in_a     (ch_a[g]),
      .in_rm    (ch_rm[g]),
      .in_row   (ch_row[g]),
      .out_v    (ch_v[g+1]),
      .out_a    (ch_a[g+1]),
      .out_rm   (ch_rm[g+1]),
      .out_row  (ch_row[g+1]),
      .rd_addr  (ti_r),
      .rd_data  (c_rd[g]),
      .best     (c_best[g]),
      .best_row (c_brow[g])
    );
  end

  // memories: sequences and answer buffer
  always_ff @(posedge clk) begin
    if (acc && (cmd_t'(in_tuser) == CMD_LOAD_A) && (fcnt_r < FCW'(FD))) begin
      fmem[fcnt_r[FIW-1:0]] <= in_val;
    end
    if (acc && (cmd_t'(in_tuser) == CMD_LOAD_B) && (scnt_r < SCW'(SD))) begin
      smem[scnt_r[SIW-1:0]] <= in_val;
    end
    f_rd_r     <= fmem[k_r[FIW-1:0]];
    tok0_row_r <= k_r[FIW-1:0];
    s_rd_r     <= smem[s_raddr];
    a_rd_r     <= amem[SIW'(ei_r - LW'(1))];
    if (st_r == S_TINIT2) begin
      amem[0] <= s_rd_r;
    end else if ((st_r == S_TCHK) && (sel_rd == need_r)) begin
      amem[found_r[SIW-1:0]] <= s_rd_r;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      fcnt_r   <= '0;
      scnt_r   <= '0;
      tok0_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (out_v_r && out_tready && !out_load) begin
        out_v_r <= 1'b0;
      end
      tok0_v_r <= (st_r == S_RUN) && (k_r < KW'(fcnt_r));
      unique case (st_r)
        S_IDLE: begin
          if (acc) begin
            unique case (cmd_t'(in_tuser))
              CMD_LOAD_A: if (fcnt_r < FCW'(FD)) fcnt_r <= fcnt_r + FCW'(1);
              CMD_LOAD_B: if (scnt_r < SCW'(SD)) scnt_r <= scnt_r + SCW'(1);
              CMD_START: begin
                k_r  <= '0;
                st_r <= S_RUN;
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          k_r <= k_r + KW'(1);
          if (k_r == KW'(fcnt_r) + KW'(SD + 1)) begin
            j_r   <= '0;
            len_r <= '0;
            bi_r  <= '0;
            bj_r  <= '0;
            st_r  <= S_RED;
          end
        end
        S_RED: begin
          if (j_r == scnt_r) begin
            st_r <= (len_r == '0) ? S_ELEN : S_TINIT;
          end else begin
            if ((sel_best > len_r) ||
                ((sel_best == len_r) && (sel_best != '0) && (sel_row < bi_r))) begin
              len_r <= sel_best;
              bi_r  <= sel_row;
              bj_r  <= j_r[SIW-1:0];
            end
            j_r <= j_r + SCW'(1);
          end
        end
        S_TINIT: st_r <= S_TINIT2;
        S_TINIT2: begin
          prev_r  <= s_rd_r;
          found_r <= LW'(1);
          need_r  <= len_r - LW'(1);
          rlim_r  <= bi_r;
          jj_r    <= SCW'(bj_r);
          st_r    <= S_TCOL;
        end
        S_TCOL: begin
          if ((jj_r == '0) || (need_r == '0)) begin
            st_r <= S_ELEN;
          end else begin
            ti_r <= '0;
            st_r <= S_TSEC;
          end
        end
        S_TSEC: begin
          if ((s_rd_r < prev_r) && (rlim_r != '0)) begin
            st_r <= S_TRD;
          end else begin
            jj_r <= jj_r - SCW'(1);
            st_r <= S_TCOL;
          end
        end
        S_TRD: st_r <= S_TCHK;
        S_TCHK: begin
          if (sel_rd == need_r) begin
            found_r <= found_r + LW'(1);
            need_r  <= need_r - LW'(1);
            rlim_r  <= ti_r;
            prev_r  <= s_rd_r;
            jj_r    <= jj_r - SCW'(1);
            st_r    <= S_TCOL;
          end else if (ti_r + FIW'(1) == rlim_r) begin
            jj_r <= jj_r - SCW'(1);
            st_r <= S_TCOL;
          end else begin
            ti_r <= ti_r + FIW'(1);
            st_r <= S_TRD;
          end
        end
        S_ELEN: begin
          if (out_free) begin
            out_v_r <= 1'b1;
            out_k_r <= KIND_LEN;
            out_d_r <= DATA_W'(len_r);
            out_l_r <= (len_r == '0);
            ei_r    <= found_r;
            st_r    <= (len_r == '0) ? S_IDLE : S_ERD;
          end
        end
        S_ERD: st_r <= S_EOUT;
        S_EOUT: begin
          if (out_free) begin
            out_v_r <= 1'b1;
            out_k_r <= KIND_ELEM;
            out_d_r <= a_ext[DATA_W-1:0];
            out_l_r <= (ei_r == LW'(1));
            ei_r    <= ei_r - LW'(1);
            st_r    <= (ei_r == LW'(1)) ? S_IDLE : S_ERD;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_k_r;
  assign out_tlast  = out_l_r;

`ifndef SYNTH
  // load counts never pass capacity
  a_fcnt: assert property (@(posedge clk) disable iff (!rst_n)
    (fcnt_r <= FCW'(FD)) && (scnt_r <= SCW'(SD)))
    else $error("load count beyond capacity");

  // the trace never needs more than the best length
  a_need: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_TCHK) |-> (need_r < len_r) && (found_r <= len_r))
    else $error("trace bookkeeping out of range");

  // a new element is written to the output only when the old one was taken
  a_ovw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready && (st_r == S_EOUT)) |=> $stable(out_d_r))
    else $error("output word overwritten under stall");

  // the last element word ends the run and frees the input
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_EOUT) && out_free && (ei_r == LW'(1))) |=> in_tready && out_tlast)
    else $error("run did not close on its last word");
`endif

endmodule

### hdl/lcis_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcis_cell
// One column cell: holds one second-sequence element, the best length
// ending at this column and the column of match lengths for every row.
// ----------------------------------------------------------------------------
module lcis_cell #(
  parameter int VW = 32,
  parameter int FD = 32,
  parameter int SD = 32,
  parameter int J  = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 b_we,
  input  logic signed [VW-1:0] b_val,
  input  logic [$clog2(SD+1)-1:0] m_cnt,
  input  logic                 in_v,
  input  logic signed [VW-1:0] in_a,
  input  logic [$clog2(SD+1)-1:0] in_rm,
  input  logic [((FD > 1) ? $clog2(FD) : 1)-1:0] in_row,
  output logic                 out_v,
  output logic signed [VW-1:0] out_a,
  output logic [$clog2(SD+1)-1:0] out_rm,
  output logic [((FD > 1) ? $clog2(FD) : 1)-1:0] out_row,
  input  logic [((FD > 1) ? $clog2(FD) : 1)-1:0] rd_addr,
  output logic [$clog2(SD+1)-1:0] rd_data,
  output logic [$clog2(SD+1)-1:0] best,
  output logic [((FD > 1) ? $clog2(FD) : 1)-1:0] best_row
);

  localparam int FIW = (FD > 1) ? $clog2(FD) : 1;
  localparam int SCW = $clog2(SD + 1);
  localparam int LW  = $clog2(SD + 1);

  logic signed [VW-1:0] b_r;
  logic [LW-1:0]        best_r;
  logic [FIW-1:0]       row_r;
  logic                 out_v_r;
  logic signed [VW-1:0] out_a_r;
  logic [LW-1:0]        out_rm_r;
  logic [FIW-1:0]       out_row_r;
  logic [LW-1:0]        rd_r;
  logic [LW-1:0]        colmem [FD];

  logic          act;
  logic          eq;
  logic          gt;
  logic [LW-1:0] cellv;
  logic [LW-1:0] rm_nxt;

  // cell compare against the passing row word
  always_comb begin
    act    = in_v && (SCW'(J) < m_cnt);
    eq     = (in_a == b_r);
    gt     = (in_a > b_r);
    cellv  = eq ? (in_rm + LW'(1)) : '0;
    rm_nxt = (act && gt && (best_r > in_rm)) ? best_r : in_rm;
  end

  // control and column best
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      best_r  <= '0;
    end else begin
      out_v_r <= in_v;
      if (clear) begin
        best_r <= '0;
      end else if (act && eq && (cellv > best_r)) begin
        best_r <= cellv;
        row_r  <= in_row;
      end
    end
  end

  // payload to the next cell, element load, column table
  always_ff @(posedge clk) begin
    out_a_r   <= in_a;
    out_rm_r  <= rm_nxt;
    out_row_r <= in_row;
    if (b_we) begin
      b_r <= b_val;
    end
    if (in_v) begin
      colmem[in_row] <= cellv;
    end
    rd_r <= colmem[rd_addr];
  end

  assign out_v    = out_v_r;
  assign out_a    = out_a_r;
  assign out_rm   = out_rm_r;
  assign out_row  = out_row_r;
  assign rd_data  = rd_r;
  assign best     = best_r;
  assign best_row = row_r;

endmodule
